/* sv/bitmap_overlap_reject_assert.svh */
// Assertion macros shared by the overlap reject RTL.
`ifndef BITMAP_OVERLAP_REJECT_ASSERT_SVH
`define BITMAP_OVERLAP_REJECT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define BOR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bitmap_overlap_reject assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BOR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bitmap_overlap_reject assertion failed");

`else

`define BOR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BOR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/bor_pkg.sv */
// Package with the request codes, register indexes and state type of the overlap reject block.
package bor_pkg;

	localparam logic [1:0] REQ_FIXED = 2'd0;
	localparam logic [1:0] REQ_SHAPE = 2'd1;
	localparam logic [1:0] REQ_TEST  = 2'd2;

	localparam logic [1:0] CFG_FIXED_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FIXED_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_SHAPE_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_SHAPE_HEIGHT = 2'd3;

	localparam int FIXED_SIZE_BITS = 9;
	localparam int SHAPE_SIZE_BITS = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} bor_state_t;

endpackage

/* sv/bitmap_overlap_reject.sv */
// Overlap reject block: tests a shape bitmap against a fixed occupancy bitmap at a signed offset.
//
// Both bitmaps live in row-wide synchronous memories and are loaded one pixel per
// transaction; a pixel write returns nothing. A test transaction scans the configured
// shape rows, reading one shape row and the matching fixed row per cycle and ANDing
// the shape row against the fixed row shifted by place_x. A test passes through the
// scan state (one step per shape row), a drain state for the memory read and a done
// state that loads the result once the output register is free. When any configured
// size is zero the test skips the scan and answers 0. The result sits in an output
// register, so the block takes the next transaction while it waits.
// Configuration registers may be written only while the block is idle.
`include "bitmap_overlap_reject_assert.svh"

module bitmap_overlap_reject
	import bor_pkg::*;
#(
	parameter int FIXED_MAX_W = 256,
	parameter int FIXED_MAX_H = 256,
	parameter int SHAPE_MAX_W = 64,
	parameter int SHAPE_MAX_H = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [FIXED_SIZE_BITS-1:0] cfg_data,

	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [1:0]                 req_type,
	input  logic [7:0]                 pixel_col,
	input  logic [7:0]                 pixel_row,
	input  logic                       pixel_set,
	input  logic signed [15:0]         place_x,
	input  logic signed [15:0]         place_y,

	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic                       rejected
);

	localparam int FCW  = $clog2(FIXED_MAX_W);
	localparam int FRW  = $clog2(FIXED_MAX_H);
	localparam int SCW  = $clog2(SHAPE_MAX_W);
	localparam int SRW  = $clog2(SHAPE_MAX_H);
	localparam int FWW  = $clog2(FIXED_MAX_W + 1);
	localparam int FHW  = $clog2(FIXED_MAX_H + 1);
	localparam int SWW  = $clog2(SHAPE_MAX_W + 1);
	localparam int SHW  = $clog2(SHAPE_MAX_H + 1);
	localparam int EXTW = FIXED_MAX_W + SHAPE_MAX_W;
	localparam int SAW  = $clog2(EXTW);

	// Configuration registers.
	logic [FIXED_SIZE_BITS-1:0] fixed_width_q;
	logic [FIXED_SIZE_BITS-1:0] fixed_height_q;
	logic [SHAPE_SIZE_BITS-1:0] shape_width_q;
	logic [SHAPE_SIZE_BITS-1:0] shape_height_q;

	logic [FWW-1:0] fw;
	logic [FHW-1:0] fh;
	logic [SWW-1:0] sw;
	logic [SHW-1:0] sh;
	logic           fail_open;

	// Row-wide bitmap memories.
	logic [FIXED_MAX_W-1:0] fmem [FIXED_MAX_H];
	logic [SHAPE_MAX_W-1:0] smem [SHAPE_MAX_H];

	bor_state_t state_q, state_d;

	logic req_acc;
	logic test_acc;
	logic fixed_we;
	logic shape_we;
	logic scan_en;
	logic load_rsp;

	logic signed [17:0] px_ext;
	logic signed [17:0] sh_sum;
	logic               col_ok;
	logic               col_ok_q;
	logic [SAW-1:0]     shamt_q;
	logic signed [15:0] py_q;
	logic [SRW-1:0]     y_q;
	logic               last_row;
	logic signed [16:0] fy;
	logic               fy_ok;

	logic                   issue_s1;
	logic                   fy_ok_s1;
	logic [FIXED_MAX_W-1:0] frow_s1;
	logic [SHAPE_MAX_W-1:0] srow_s1;

	logic [FIXED_MAX_W-1:0] fmask;
	logic [SHAPE_MAX_W-1:0] smask;
	logic [EXTW-1:0]        ext_row;
	logic [EXTW-1:0]        ext_shift;
	logic [SHAPE_MAX_W-1:0] win;
	logic                   hit;
	logic                   acc_q;

	logic rsp_valid_q;
	logic rejected_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_width_q  <= '0;
			fixed_height_q <= '0;
			shape_width_q  <= '0;
			shape_height_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FIXED_WIDTH:  fixed_width_q  <= cfg_data;
				CFG_FIXED_HEIGHT: fixed_height_q <= cfg_data;
				CFG_SHAPE_WIDTH:  shape_width_q  <= cfg_data[SHAPE_SIZE_BITS-1:0];
				CFG_SHAPE_HEIGHT: shape_height_q <= cfg_data[SHAPE_SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Sizes above the storage limits saturate to those limits.
	always_comb begin
		fw = (32'(fixed_width_q) > FIXED_MAX_W) ? FWW'(FIXED_MAX_W) : FWW'(fixed_width_q);
		fh = (32'(fixed_height_q) > FIXED_MAX_H) ? FHW'(FIXED_MAX_H) : FHW'(fixed_height_q);
		sw = (32'(shape_width_q) > SHAPE_MAX_W) ? SWW'(SHAPE_MAX_W) : SWW'(shape_width_q);
		sh = (32'(shape_height_q) > SHAPE_MAX_H) ? SHW'(SHAPE_MAX_H) : SHW'(shape_height_q);
		fail_open = (fw == '0) || (fh == '0) || (sw == '0) || (sh == '0);
	end

	assign req_acc  = req_valid && !req_stall;
	assign test_acc = req_acc && (req_type == REQ_TEST);
	assign fixed_we = req_acc && (req_type == REQ_FIXED)
		&& (32'(pixel_col) < FIXED_MAX_W) && (32'(pixel_row) < FIXED_MAX_H);
	assign shape_we = req_acc && (req_type == REQ_SHAPE)
		&& (32'(pixel_col) < SHAPE_MAX_W) && (32'(pixel_row) < SHAPE_MAX_H);

	// Horizontal placement: the fixed row is padded below by SHAPE_MAX_W zero columns so that
	// a shift by place_x + SHAPE_MAX_W lines fixed column place_x + x up with shape column x.
	always_comb begin
		px_ext = 18'(place_x);
		sh_sum = px_ext + 18'(SHAPE_MAX_W);
		col_ok = (px_ext > -SHAPE_MAX_W) && (px_ext < FIXED_MAX_W);
	end

	always_ff @(posedge clk) begin
		if (test_acc) begin
			col_ok_q <= col_ok;
			shamt_q  <= sh_sum[SAW-1:0];
			py_q     <= place_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (test_acc) begin
					state_d = fail_open ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_row) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		scan_en   = 1'b0;
		load_rsp  = 1'b0;
		case (state_q)
			ST_IDLE:  req_stall = 1'b0;
			ST_SCAN:  scan_en = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  load_rsp = !rsp_valid_q || !rsp_stall;
			default: ;
		endcase
	end

	// Row counter of the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q <= '0;
		end else if (test_acc) begin
			y_q <= '0;
		end else if (scan_en) begin
			y_q <= y_q + 1'b1;
		end
	end

	always_comb begin
		last_row = (32'(y_q) + 1) == 32'(sh);
		fy       = 17'(py_q) + 17'(y_q);
		fy_ok    = !fy[16] && (fy[15:0] < 16'(fh));
	end

	// Memories: single-pixel writes, one row read per cycle while scanning, with registered data.
	always_ff @(posedge clk) begin
		if (fixed_we) begin
			fmem[FRW'(pixel_row)][FCW'(pixel_col)] <= pixel_set;
		end
		if (shape_we) begin
			smem[SRW'(pixel_row)][SCW'(pixel_col)] <= pixel_set;
		end
		if (scan_en) begin
			frow_s1 <= fmem[fy[FRW-1:0]];
			srow_s1 <= smem[y_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			fy_ok_s1 <= 1'b0;
		end else begin
			issue_s1 <= scan_en;
			fy_ok_s1 <= fy_ok;
		end
	end

	// Columns outside the configured areas never count.
	always_comb begin
		for (int k = 0; k < FIXED_MAX_W; k++) begin
			fmask[k] = k < int'(fw);
		end
		for (int x = 0; x < SHAPE_MAX_W; x++) begin
			smask[x] = x < int'(sw);
		end
		ext_row   = {frow_s1 & fmask, {SHAPE_MAX_W{1'b0}}};
		ext_shift = ext_row >> shamt_q;
		win       = ext_shift[SHAPE_MAX_W-1:0];
		hit       = col_ok_q && fy_ok_s1 && (|(win & srow_s1 & smask));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 1'b0;
		end else if (test_acc) begin
			acc_q <= 1'b0;
		end else if (issue_s1) begin
			acc_q <= acc_q | hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rejected_q <= acc_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rejected  = rejected_q;

	`BOR_ASSERT_NXT(a_fail_open_skips_scan, clk, arst_n, test_acc && fail_open, state_q == ST_DONE)
	`BOR_ASSERT_IMP(a_issue_only_in_scan, clk, arst_n, issue_s1, state_q == ST_SCAN || state_q == ST_DRAIN)
	`BOR_ASSERT_NXT(a_drain_to_done, clk, arst_n, state_q == ST_DRAIN, state_q == ST_DONE)
	`BOR_ASSERT_IMP(a_rsp_from_done, clk, arst_n, $rose(rsp_valid_q), $past(state_q == ST_DONE))
	`BOR_ASSERT_IMP(a_row_in_range, clk, arst_n, state_q == ST_SCAN, 32'(y_q) < 32'(sh))

endmodule

/* dv/tb.sv */
// Self-checking testbench for the bitmap overlap reject block.
`timescale 1ns / 100ps

module tb;
	import bor_pkg::*;

	localparam int FIXED_W_MAX = 256;
	localparam int FIXED_H_MAX = 256;
	localparam int SHAPE_W_MAX = 64;
	localparam int SHAPE_H_MAX = 64;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int SETTLE_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct {
		bit rejected;
		int px;
		int py;
	} reject_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = 2'd0;
	logic [FIXED_SIZE_BITS-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] req_type = REQ_FIXED;
	logic [7:0] pixel_col = 8'd0;
	logic [7:0] pixel_row = 8'd0;
	logic pixel_set = 1'b0;
	logic signed [15:0] place_x = 16'sd0;
	logic signed [15:0] place_y = 16'sd0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic rejected;

	// Shadow copy of both bitmaps, which entries have been written, and the saturated sizes.
	bit fixed_img [FIXED_H_MAX][FIXED_W_MAX];
	bit fixed_wr [FIXED_H_MAX][FIXED_W_MAX];
	bit shape_img [SHAPE_H_MAX][SHAPE_W_MAX];
	bit shape_wr [SHAPE_H_MAX][SHAPE_W_MAX];
	int fixed_w = 0;
	int fixed_h = 0;
	int shape_w = 0;
	int shape_h = 0;

	reject_exp_t pending_rejects [$];
	int mismatch_count = 0;
	int gap_max = 0;
	int burst_left = 0;
	int hold_request = 0;

	bitmap_overlap_reject #(
		.FIXED_MAX_W(FIXED_W_MAX),
		.FIXED_MAX_H(FIXED_H_MAX),
		.SHAPE_MAX_W(SHAPE_W_MAX),
		.SHAPE_MAX_H(SHAPE_H_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.pixel_set(pixel_set),
		.place_x(place_x),
		.place_y(place_y),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rejected(rejected)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic bit predict_reject(int px, int py);
		int fx;
		int fy;
		if (fixed_w == 0 || fixed_h == 0 || shape_w == 0 || shape_h == 0)
			return 1'b0;
		for (int y = 0; y < shape_h; y++) begin
			fy = py + y;
			if (fy < 0 || fy >= fixed_h)
				continue;
			for (int x = 0; x < shape_w; x++) begin
				if (!shape_img[y][x])
					continue;
				fx = px + x;
				if (fx < 0 || fx >= fixed_w)
					continue;
				if (fixed_img[fy][fx])
					return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Offers one request transaction, with a random gap between bursts, and updates the shadow
	// state once the block takes it.
	task automatic send_item(input logic [1:0] kind, input logic [7:0] col, input logic [7:0] row,
			input logic set, input logic [15:0] px, input logic [15:0] py);
		reject_exp_t exp_item;
		int gap;
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				gap = $urandom_range(1, gap_max);
				repeat (gap) begin
					@(negedge clk);
					req_valid <= 1'b0;
				end
			end
			burst_left--;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req_type <= kind;
		pixel_col <= col;
		pixel_row <= row;
		pixel_set <= set;
		place_x <= px;
		place_y <= py;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
		case (kind)
			REQ_FIXED: begin
				fixed_img[row][col] = set;
				fixed_wr[row][col] = 1'b1;
			end
			REQ_SHAPE: begin
				if (col < SHAPE_W_MAX && row < SHAPE_H_MAX) begin
					shape_img[row][col] = set;
					shape_wr[row][col] = 1'b1;
				end
			end
			REQ_TEST: begin
				exp_item.px = $signed(px);
				exp_item.py = $signed(py);
				exp_item.rejected = predict_reject(exp_item.px, exp_item.py);
				pending_rejects.push_back(exp_item);
			end
			default: ;
		endcase
	endtask

	task automatic send_test(input int px, input int py);
		send_item(REQ_TEST, 8'($urandom), 8'($urandom), 1'($urandom), 16'(px), 16'(py));
	endtask

	task automatic send_pixel(input logic [1:0] kind, input int col, input int row, input bit set);
		send_item(kind, 8'(col), 8'(row), set, 16'($urandom), 16'($urandom));
	endtask

	task automatic sender_rest();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	task automatic wait_results_drained();
		while (pending_rejects.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_size_reg(input logic [1:0] idx, input logic [FIXED_SIZE_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		case (idx)
			CFG_FIXED_WIDTH: fixed_w = (data > FIXED_W_MAX) ? FIXED_W_MAX : int'(data);
			CFG_FIXED_HEIGHT: fixed_h = (data > FIXED_H_MAX) ? FIXED_H_MAX : int'(data);
			CFG_SHAPE_WIDTH: shape_w = (data[6:0] > SHAPE_W_MAX) ? SHAPE_W_MAX : int'(data[6:0]);
			CFG_SHAPE_HEIGHT: shape_h = (data[6:0] > SHAPE_H_MAX) ? SHAPE_H_MAX : int'(data[6:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reconfigures once the block is idle, then writes every entry of the new areas that has
	// never been written, so that no test reads an undefined pixel.
	task automatic set_sizes(input logic [8:0] fw_raw, input logic [8:0] fh_raw,
			input logic [8:0] sw_raw, input logic [8:0] sh_raw, input int fill_pct);
		sender_rest();
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_size_reg(CFG_FIXED_WIDTH, fw_raw);
		write_size_reg(CFG_FIXED_HEIGHT, fh_raw);
		write_size_reg(CFG_SHAPE_WIDTH, sw_raw);
		write_size_reg(CFG_SHAPE_HEIGHT, sh_raw);
		for (int r = 0; r < fixed_h; r++)
			for (int c = 0; c < fixed_w; c++)
				if (!fixed_wr[r][c])
					send_pixel(REQ_FIXED, c, r, $urandom_range(0, 99) < fill_pct);
		for (int r = 0; r < shape_h; r++)
			for (int c = 0; c < shape_w; c++)
				if (!shape_wr[r][c])
					send_pixel(REQ_SHAPE, c, r, $urandom_range(0, 99) < fill_pct);
	endtask

	// Returns counted = 0 for a transaction the block ignores.
	task automatic send_random_item(output bit counted);
		int pick;
		int px;
		int py;
		int col;
		int row;
		pick = $urandom_range(0, 99);
		counted = 1'b1;
		if (pick < 45) begin
			if ($urandom_range(0, 99) < 85) begin
				px = int'($urandom_range(0, fixed_w + shape_w + 1)) - shape_w - 1;
				py = int'($urandom_range(0, fixed_h + shape_h + 1)) - shape_h - 1;
			end else begin
				px = $signed(16'($urandom));
				py = $signed(16'($urandom));
			end
			send_test(px, py);
		end else if (pick < 70) begin
			if (fixed_w > 0 && fixed_h > 0 && $urandom_range(0, 99) < 80) begin
				col = $urandom_range(0, fixed_w - 1);
				row = $urandom_range(0, fixed_h - 1);
			end else begin
				col = $urandom_range(0, 255);
				row = $urandom_range(0, 255);
			end
			send_pixel(REQ_FIXED, col, row, $urandom_range(0, 99) < 40);
		end else if (pick < 93) begin
			if (shape_w > 0 && shape_h > 0 && $urandom_range(0, 99) < 80) begin
				col = $urandom_range(0, shape_w - 1);
				row = $urandom_range(0, shape_h - 1);
			end else begin
				col = $urandom_range(0, 255);
				row = $urandom_range(0, 255);
				counted = (col < SHAPE_W_MAX && row < SHAPE_H_MAX);
			end
			send_pixel(REQ_SHAPE, col, row, $urandom_range(0, 99) < 40);
		end else begin
			send_item(REQ_UNKNOWN, 8'($urandom), 8'($urandom), 1'($urandom), 16'($urandom),
				16'($urandom));
			counted = 1'b0;
		end
	endtask

	task automatic run_random_traffic(input int n);
		int done_cnt;
		bit counted;
		done_cnt = 0;
		while (done_cnt < n) begin
			send_random_item(counted);
			if (counted)
				done_cnt++;
		end
	endtask

	task automatic pick_sender_gaps();
		case ($urandom_range(0, 2))
			0: gap_max = 0;
			1: gap_max = 3;
			default: gap_max = 8;
		endcase
	endtask

	task automatic test_fail_open_at_reset();
		send_test(0, 0);
		send_test(-32768, 32767);
		send_pixel(REQ_FIXED, 0, 0, 1'b1);
		send_test(0, 0);
	endtask

	task automatic test_directed_small();
		gap_max = 3;
		set_sizes(9'd16, 9'd16, 9'd8, 9'd8, 0);
		send_pixel(REQ_FIXED, 5, 5, 1'b1);
		send_pixel(REQ_SHAPE, 0, 0, 1'b1);
		send_test(5, 5);
		send_test(4, 5);
		send_test(6, 6);
		// Shape pixel (0,0) falls outside the fixed area here and must be ignored.
		send_pixel(REQ_SHAPE, 7, 7, 1'b1);
		send_test(-2, -2);
		send_test(32767, 32767);
		send_test(-32768, -32768);
		send_test(-32768, 32767);
		send_test(32767, -32768);
		// A shape pixel beyond the configured shape width is stored but not read.
		send_pixel(REQ_SHAPE, 10, 0, 1'b1);
		send_test(-5, 5);
		send_pixel(REQ_SHAPE, 64, 0, 1'b1);
		send_pixel(REQ_SHAPE, 255, 255, 1'b1);
		send_pixel(REQ_FIXED, 20, 5, 1'b1);
		send_test(20, 5);
		send_item(REQ_UNKNOWN, 8'hff, 8'hff, 1'b1, 16'hffff, 16'hffff);
		send_pixel(REQ_FIXED, 5, 5, 1'b0);
		send_test(5, 5);
		send_test(-2, -2);
		send_pixel(REQ_FIXED, 15, 15, 1'b1);
		send_test(8, 8);
		send_pixel(REQ_FIXED, 0, 0, 1'b1);
		send_test(0, 0);
		// Widening the areas brings the pixels written outside them into play.
		set_sizes(9'd24, 9'd16, 9'd16, 9'd8, 0);
		send_test(10, 5);
	endtask

	task automatic test_wide_sizes();
		pick_sender_gaps();
		set_sizes(9'd300, 9'd2, 9'd127, 9'd4, 30);
		send_pixel(REQ_FIXED, 255, 1, 1'b1);
		send_pixel(REQ_SHAPE, 63, 3, 1'b1);
		send_test(192, -2);
		run_random_traffic(60);
	endtask

	task automatic test_tall_sizes();
		pick_sender_gaps();
		set_sizes(9'd4, 9'd511, 9'd4, 9'h1c0, 30);
		send_pixel(REQ_FIXED, 3, 255, 1'b1);
		send_pixel(REQ_SHAPE, 3, 63, 1'b1);
		send_test(0, 192);
		run_random_traffic(60);
	endtask

	task automatic test_zero_size_fail_open();
		pick_sender_gaps();
		set_sizes(9'd0, 9'd12, 9'd6, 9'd6, 50);
		run_random_traffic(15);
		set_sizes(9'd12, 9'd0, 9'd6, 9'd6, 50);
		run_random_traffic(15);
		// The shape registers keep seven bits, so these upper bits leave a zero size.
		set_sizes(9'd12, 9'd12, 9'h180, 9'd6, 50);
		run_random_traffic(15);
		set_sizes(9'd12, 9'd12, 9'd6, 9'h080, 50);
		run_random_traffic(15);
	endtask

	task automatic test_random_sizes();
		for (int i = 0; i < 6; i++) begin
			pick_sender_gaps();
			set_sizes(9'($urandom_range(1, 24)), 9'($urandom_range(1, 24)),
				{2'($urandom), 7'($urandom_range(1, 8))},
				{2'($urandom), 7'($urandom_range(1, 8))}, $urandom_range(15, 50));
			run_random_traffic(55);
		end
	endtask

	task automatic test_backpressure();
		gap_max = 0;
		set_sizes(9'd16, 9'd16, 9'd4, 9'd4, 35);
		hold_request = 300;
		for (int i = 0; i < 40; i++)
			send_test($urandom_range(0, 20) - 4, $urandom_range(0, 20) - 4);
		sender_rest();
		wait_results_drained();
		gap_max = 3;
		run_random_traffic(40);
	endtask

	// Receiver: random stall density that changes in stretches, plus an optional long hold-off.
	initial begin : receiver
		int hold_left;
		int pattern_left;
		int stall_pct;
		hold_left = 0;
		pattern_left = 0;
		stall_pct = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				if (pattern_left == 0) begin
					pattern_left = $urandom_range(20, 200);
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 10;
						2: stall_pct = 40;
						default: stall_pct = 75;
					endcase
				end
				pattern_left--;
				rsp_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		reject_exp_t exp_item;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (pending_rejects.size() == 0) begin
				report_mismatch("result transaction with no test pending");
			end else begin
				exp_item = pending_rejects.pop_front();
				if (rejected !== exp_item.rejected)
					report_mismatch($sformatf("place (%0d,%0d): rejected %b, expected %b",
						exp_item.px, exp_item.py, rejected, exp_item.rejected));
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[%0t] no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_fail_open_at_reset();
		test_directed_small();
		test_wide_sizes();
		test_tall_sizes();
		test_zero_size_fail_open();
		test_random_sizes();
		test_backpressure();
		sender_rest();
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
